// ===== rtl/core/rbb_pkg.sv =====
// Shared types and constants for the ray box bounce block.
package rbb_pkg;

  localparam int POS_W    = 31;
  localparam int DIR_W    = 16;
  localparam int TOT_W    = 47;
  localparam int DIR_FRAC = 14;
  localparam int QUO_W    = POS_W + DIR_FRAC;
  localparam int PROD_W   = QUO_W + DIR_W;
  localparam int CNT_W    = 6;

  localparam logic [1:0] WALL_NONE = 2'd3;
  localparam logic [1:0] AXIS_LAST = 2'd2;

  localparam logic [1:0] CFG_BOX_X = 2'd0;
  localparam logic [1:0] CFG_BOX_Y = 2'd1;
  localparam logic [1:0] CFG_BOX_Z = 2'd2;

  localparam logic [POS_W-1:0] BOX_RESET = 31'd6553600;

  typedef enum logic {
    ALU_DIV,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_FIN,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/core/ray_box_bounce_step.sv =====
// Top level: ray state, bounce sequencer and result register.
// A load item goes from idle to ST_EMIT, which places its result in the output register.
// A bounce item runs three divisions and three multiplications on one shared unit, then a
// finishing and an emit state. A zero direction component skips its division; with all three
// zero no wall is chosen and the item goes to ST_EMIT without multiplying. One item is worked at
// a time; in_stall is high from acceptance until the result is placed in the output register.
// Reset sets box sizes to 100.0 and clears state, axis, valid, total, positions and directions.
module ray_box_bounce_step (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_idx,
  input  logic [rbb_pkg::POS_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [rbb_pkg::POS_W-1:0]       in_start_x,
  input  logic [rbb_pkg::POS_W-1:0]       in_start_y,
  input  logic [rbb_pkg::POS_W-1:0]       in_start_z,
  input  logic signed [rbb_pkg::DIR_W-1:0] in_start_dir_x,
  input  logic signed [rbb_pkg::DIR_W-1:0] in_start_dir_y,
  input  logic signed [rbb_pkg::DIR_W-1:0] in_start_dir_z,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rbb_pkg::POS_W-1:0]       out_pos_x,
  output logic [rbb_pkg::POS_W-1:0]       out_pos_y,
  output logic [rbb_pkg::POS_W-1:0]       out_pos_z,
  output logic signed [rbb_pkg::DIR_W-1:0] out_dir_x,
  output logic signed [rbb_pkg::DIR_W-1:0] out_dir_y,
  output logic signed [rbb_pkg::DIR_W-1:0] out_dir_z,
  output logic [1:0]                      out_hit_wall,
  output logic [rbb_pkg::POS_W-1:0]       out_step_length,
  output logic [rbb_pkg::TOT_W-1:0]       out_total_path
);

  localparam int POS_W  = rbb_pkg::POS_W;
  localparam int DIR_W  = rbb_pkg::DIR_W;
  localparam int TOT_W  = rbb_pkg::TOT_W;
  localparam int QUO_W  = rbb_pkg::QUO_W;
  localparam int PROD_W = rbb_pkg::PROD_W;
  localparam int FRAC   = rbb_pkg::DIR_FRAC;
  localparam int EXT_W  = TOT_W + 2;

  rbb_pkg::state_t         state_r, state_nxt;
  logic [1:0]              ax_r, ax_nxt;
  logic [POS_W-1:0]        box_r [3];
  logic [POS_W-1:0]        pos_r [3];
  logic [POS_W-1:0]        pos_nxt [3];
  logic [DIR_W-1:0]        dir_r [3];
  logic [DIR_W-1:0]        dir_nxt [3];
  logic [TOT_W-1:0]        total_r, total_nxt;
  logic                    best_ok_r, best_ok_nxt;
  logic [1:0]              best_ax_r, best_ax_nxt;
  logic [QUO_W-1:0]        best_mag_r, best_mag_nxt;
  logic                    best_neg_r, best_neg_nxt;
  logic                    dist_neg_r, dist_neg_nxt;
  logic [1:0]              wall_r, wall_nxt;
  logic [POS_W-1:0]        step_r, step_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]        o_pos_r [3];
  logic [DIR_W-1:0]        o_dir_r [3];
  logic [1:0]              o_wall_r;
  logic [POS_W-1:0]        o_step_r;
  logic [TOT_W-1:0]        o_total_r;
  logic                    emit_go;

  rbb_pkg::alu_ctl_t       alu_ctl;
  logic [QUO_W-1:0]        alu_a;
  logic [DIR_W-1:0]        alu_b;
  logic                    alu_done;
  logic [PROD_W-1:0]       alu_res;

  logic [DIR_W-1:0]        cur_dir;
  logic [DIR_W-1:0]        cur_mag;
  logic [POS_W+1:0]        wall_dist;
  logic [POS_W+1:0]        dist_abs;
  logic [QUO_W-1:0]        quo;
  logic                    quo_better;
  logic [TOT_W-1:0]        delta;
  logic                    mv_neg;
  logic [EXT_W-1:0]        pos_ext;
  logic [EXT_W-1:0]        pos_mv;
  logic [EXT_W-1:0]        box_ext;
  logic [DIR_W-1:0]        hit_dir;
  logic [TOT_W:0]          total_sum;
  logic                    in_acc;

  rbb_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (alu_ctl),
    .a_in   (alu_a),
    .b_in   (alu_b),
    .done   (alu_done),
    .result (alu_res)
  );

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != rbb_pkg::ST_IDLE);
  assign emit_go  = (state_r == rbb_pkg::ST_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    cur_dir  = dir_r[ax_r];
    cur_mag  = cur_dir[DIR_W-1] ? (~cur_dir + 1'b1) : cur_dir;
    if (!cur_dir[DIR_W-1]) begin
      wall_dist = {2'b00, box_r[ax_r]} - {2'b00, pos_r[ax_r]};
    end else begin
      wall_dist = '0 - {2'b00, pos_r[ax_r]};
    end
    dist_abs = wall_dist[POS_W+1] ? ('0 - wall_dist) : wall_dist;
    quo        = alu_res[QUO_W-1:0];
    quo_better = !best_ok_r || (quo < best_mag_r);
    delta      = alu_res[PROD_W-1:FRAC];
    mv_neg     = best_neg_r != cur_dir[DIR_W-1];
    pos_ext    = {{(EXT_W-POS_W){1'b0}}, pos_r[ax_r]};
    box_ext    = {{(EXT_W-POS_W){1'b0}}, box_r[ax_r]};
    pos_mv     = mv_neg ? (pos_ext - {2'b00, delta}) : (pos_ext + {2'b00, delta});
    hit_dir    = dir_r[best_ax_r];
    total_sum  = {1'b0, total_r} + {{(TOT_W-POS_W+1){1'b0}}, step_r};
  end

  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    pos_nxt       = pos_r;
    dir_nxt       = dir_r;
    total_nxt     = total_r;
    best_ok_nxt   = best_ok_r;
    best_ax_nxt   = best_ax_r;
    best_mag_nxt  = best_mag_r;
    best_neg_nxt  = best_neg_r;
    dist_neg_nxt  = dist_neg_r;
    wall_nxt      = wall_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    alu_ctl.start = 1'b0;
    alu_ctl.op    = rbb_pkg::ALU_DIV;
    alu_a         = {dist_abs[POS_W-1:0], {FRAC{1'b0}}};
    alu_b         = cur_mag;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      rbb_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!in_kind) begin
            pos_nxt[0] = in_start_x;
            pos_nxt[1] = in_start_y;
            pos_nxt[2] = in_start_z;
            dir_nxt[0] = in_start_dir_x;
            dir_nxt[1] = in_start_dir_y;
            dir_nxt[2] = in_start_dir_z;
            total_nxt  = '0;
            wall_nxt   = rbb_pkg::WALL_NONE;
            step_nxt   = '0;
            state_nxt  = rbb_pkg::ST_EMIT;
          end else begin
            ax_nxt      = '0;
            best_ok_nxt = 1'b0;
            state_nxt   = rbb_pkg::ST_DIV_GO;
          end
        end
      end
      rbb_pkg::ST_DIV_GO, rbb_pkg::ST_DIV_WAIT: begin
        if ((state_r == rbb_pkg::ST_DIV_GO) && (cur_dir != '0)) begin
          alu_ctl.start = 1'b1;
          dist_neg_nxt  = wall_dist[POS_W+1];
          state_nxt     = rbb_pkg::ST_DIV_WAIT;
        end else if ((state_r == rbb_pkg::ST_DIV_GO) || alu_done) begin
          if ((state_r == rbb_pkg::ST_DIV_WAIT) && quo_better) begin
            best_ok_nxt  = 1'b1;
            best_ax_nxt  = ax_r;
            best_mag_nxt = quo;
            best_neg_nxt = (quo != '0) && (dist_neg_r != cur_dir[DIR_W-1]);
          end
          if (ax_r == rbb_pkg::AXIS_LAST) begin
            ax_nxt = '0;
            if (best_ok_nxt) begin
              state_nxt = rbb_pkg::ST_MUL_GO;
            end else begin
              wall_nxt  = rbb_pkg::WALL_NONE;
              step_nxt  = '0;
              state_nxt = rbb_pkg::ST_EMIT;
            end
          end else begin
            ax_nxt    = ax_r + 1'b1;
            state_nxt = rbb_pkg::ST_DIV_GO;
          end
        end
      end
      rbb_pkg::ST_MUL_GO: begin
        alu_ctl.start = 1'b1;
        alu_ctl.op    = rbb_pkg::ALU_MUL;
        alu_a         = best_mag_r;
        state_nxt     = rbb_pkg::ST_MUL_WAIT;
      end
      rbb_pkg::ST_MUL_WAIT: begin
        if (alu_done) begin
          if (pos_mv[EXT_W-1]) begin
            pos_nxt[ax_r] = '0;
          end else if (pos_mv > box_ext) begin
            pos_nxt[ax_r] = box_r[ax_r];
          end else begin
            pos_nxt[ax_r] = pos_mv[POS_W-1:0];
          end
          if (ax_r == rbb_pkg::AXIS_LAST) begin
            state_nxt = rbb_pkg::ST_FIN;
          end else begin
            ax_nxt    = ax_r + 1'b1;
            state_nxt = rbb_pkg::ST_MUL_GO;
          end
        end
      end
      rbb_pkg::ST_FIN: begin
        if (hit_dir == {1'b1, {(DIR_W-1){1'b0}}}) begin
          dir_nxt[best_ax_r] = {1'b0, {(DIR_W-1){1'b1}}};
        end else begin
          dir_nxt[best_ax_r] = ~hit_dir + 1'b1;
        end
        wall_nxt = best_ax_r;
        if (best_mag_r > {{(QUO_W-POS_W){1'b0}}, {POS_W{1'b1}}}) begin
          step_nxt = {POS_W{1'b1}};
        end else begin
          step_nxt = best_mag_r[POS_W-1:0];
        end
        state_nxt = rbb_pkg::ST_EMIT;
      end
      rbb_pkg::ST_EMIT: begin
        if (wall_r != rbb_pkg::WALL_NONE) begin
          total_nxt = total_sum[TOT_W] ? {TOT_W{1'b1}} : total_sum[TOT_W-1:0];
        end
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = rbb_pkg::ST_IDLE;
        end else begin
          total_nxt = total_r;
        end
      end
      default: begin
        state_nxt = rbb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rbb_pkg::ST_IDLE;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
      best_ok_r   <= 1'b0;
      total_r     <= '0;
      for (int i = 0; i < 3; i++) begin
        box_r[i] <= rbb_pkg::BOX_RESET;
        pos_r[i] <= '0;
        dir_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
      best_ok_r   <= best_ok_nxt;
      total_r     <= total_nxt;
      pos_r       <= pos_nxt;
      dir_r       <= dir_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          rbb_pkg::CFG_BOX_X: box_r[0] <= cfg_wdata;
          rbb_pkg::CFG_BOX_Y: box_r[1] <= cfg_wdata;
          rbb_pkg::CFG_BOX_Z: box_r[2] <= cfg_wdata;
          default: ;
        endcase
      end
    end
    best_ax_r  <= best_ax_nxt;
    best_mag_r <= best_mag_nxt;
    best_neg_r <= best_neg_nxt;
    dist_neg_r <= dist_neg_nxt;
    wall_r     <= wall_nxt;
    step_r     <= step_nxt;
    if (emit_go) begin
      o_pos_r   <= pos_r;
      o_dir_r   <= dir_r;
      o_wall_r  <= wall_r;
      o_step_r  <= step_r;
      o_total_r <= total_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pos_x       = o_pos_r[0];
  assign out_pos_y       = o_pos_r[1];
  assign out_pos_z       = o_pos_r[2];
  assign out_dir_x       = o_dir_r[0];
  assign out_dir_y       = o_dir_r[1];
  assign out_dir_z       = o_dir_r[2];
  assign out_hit_wall    = o_wall_r;
  assign out_step_length = o_step_r;
  assign out_total_path  = o_total_r;

  a_mul_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rbb_pkg::ST_MUL_GO) |-> best_ok_r)
    else $error("multiply pass started without a chosen wall");
  a_load_clears_total: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_kind) |=> (total_r == '0))
    else $error("load did not clear the path total");
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> ((state_r == rbb_pkg::ST_DIV_WAIT) || (state_r == rbb_pkg::ST_MUL_WAIT)))
    else $error("arithmetic unit finished outside a wait state");
  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> out_valid_r)
    else $error("result not presented after emit");

endmodule

// ===== rtl/core/rbb_alu.sv =====
// Bit-serial divider and shift-add multiplier shared by all axes.
module rbb_alu (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rbb_pkg::alu_ctl_t              ctl,
  input  logic [rbb_pkg::QUO_W-1:0]      a_in,
  input  logic [rbb_pkg::DIR_W-1:0]      b_in,
  output logic                           done,
  output logic [rbb_pkg::PROD_W-1:0]     result
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  rbb_pkg::alu_op_t              op_r, op_nxt;
  logic [rbb_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [rbb_pkg::QUO_W-1:0]     q_r, q_nxt;
  logic [rbb_pkg::DIR_W-1:0]     rem_r, rem_nxt;
  logic [rbb_pkg::DIR_W-1:0]     b_r, b_nxt;
  logic [rbb_pkg::PROD_W-1:0]    acc_r, acc_nxt;
  logic [rbb_pkg::DIR_W:0]       rem_sh;
  logic [rbb_pkg::DIR_W:0]       rem_sub;
  logic [rbb_pkg::PROD_W-1:0]    addend;

  always_comb begin
    rem_sh  = {rem_r, q_r[rbb_pkg::QUO_W-1]};
    rem_sub = rem_sh - {1'b0, b_r};
    addend  = b_r[rbb_pkg::DIR_W-1] ? {{rbb_pkg::DIR_W{1'b0}}, q_r} : '0;

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;

    if (ctl.start) begin
      busy_nxt = 1'b1;
      op_nxt   = ctl.op;
      q_nxt    = a_in;
      b_nxt    = b_in;
      rem_nxt  = '0;
      acc_nxt  = '0;
      cnt_nxt  = (ctl.op == rbb_pkg::ALU_DIV) ? rbb_pkg::CNT_W'(rbb_pkg::QUO_W - 1)
                                              : rbb_pkg::CNT_W'(rbb_pkg::DIR_W - 1);
    end else if (busy_r) begin
      case (op_r)
        rbb_pkg::ALU_DIV: begin
          if (!rem_sub[rbb_pkg::DIR_W]) begin
            rem_nxt = rem_sub[rbb_pkg::DIR_W-1:0];
            q_nxt   = {q_r[rbb_pkg::QUO_W-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sh[rbb_pkg::DIR_W-1:0];
            q_nxt   = {q_r[rbb_pkg::QUO_W-2:0], 1'b0};
          end
        end
        rbb_pkg::ALU_MUL: begin
          acc_nxt = {acc_r[rbb_pkg::PROD_W-2:0], 1'b0} + addend;
          b_nxt   = {b_r[rbb_pkg::DIR_W-2:0], 1'b0};
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= rbb_pkg::ALU_DIV;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done   = done_r;
  assign result = (op_r == rbb_pkg::ALU_DIV) ? {{rbb_pkg::DIR_W{1'b0}}, q_r} : acc_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r)
    else $error("unit started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("done raised while still busy");
  a_start_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> busy_r)
    else $error("unit did not go busy after start");

endmodule
